/* rtl/core/stu_pkg.sv */
// Shared types and constants for the source tokenizer.
// Token kind codes, field widths and the token/pair structs used by all modules.
`timescale 1ns / 1ps

package stu_pkg;

	localparam int NUM_CHARS_DEF = 11;

	localparam int KIND_W = 5;
	localparam int MANT_W = 37;
	localparam int FRAC_W = 4;
	localparam int CHAR_W = 8;

	localparam logic [MANT_W-1:0] MANT_MAX = '1;
	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	localparam logic [KIND_W-1:0] K_INT     = 5'd0;
	localparam logic [KIND_W-1:0] K_FLOAT   = 5'd1;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd2;
	localparam logic [KIND_W-1:0] K_LET     = 5'd3;
	localparam logic [KIND_W-1:0] K_STRCHAR = 5'd4;
	localparam logic [KIND_W-1:0] K_STREND  = 5'd5;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd6;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd7;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd8;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd9;
	localparam logic [KIND_W-1:0] K_PCT     = 5'd10;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd11;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd12;
	localparam logic [KIND_W-1:0] K_LBRACK  = 5'd13;
	localparam logic [KIND_W-1:0] K_RBRACK  = 5'd14;
	localparam logic [KIND_W-1:0] K_LBRACE  = 5'd15;
	localparam logic [KIND_W-1:0] K_RBRACE  = 5'd16;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd17;
	localparam logic [KIND_W-1:0] K_EOF     = 5'd18;
	localparam logic [KIND_W-1:0] K_ERROR   = 5'd19;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MANT_W-1:0] mant;
		logic [FRAC_W-1:0] frac;
		logic [CHAR_W-1:0] chv;
		logic              ovf;
		logic              last;
	} token_t;

	// Up to two tokens produced by one input word; slot 1 used only when two is set.
	typedef struct packed {
		token_t [1:0] tok;
		logic         two;
	} pair_t;

endpackage

/* rtl/core/source_tokenizer_unit.sv */
// Top level of the source tokenizer: input register, lexer and result queue.
// Depends on stu_pkg, stu_lexer and stu_out_fifo.
`timescale 1ns / 1ps

// Usage
//  Input channel (in_valid/in_ready): one word per handshake, a source byte on
//  char_in, or end_mark high to flush the pending token and emit an eof token.
//  Output channel (out_valid/out_ready): one token per handshake, fields on
//  token_kind, mantissa, fraction_digits, char_value, num_overflow; last_result
//  marks the final token caused by an input word.
//  Path: an accepted word waits in the input register, is lexed from there once
//  the queue has room, and its tokens are written into the result queue and offered.
//  Throughput: one input word per cycle while each word makes at most one token
//  and out_ready stays high; a word that makes two tokens (terminator of a number
//  or identifier that is itself a token, or any end mark after a pending token)
//  holds the output until both tokens are taken. Whitespace and characters inside
//  a number or identifier make none. The two-entry result queue sets this figure:
//  the input side keeps taking words while a finished token waits to be taken.
//  Stall: when out_ready is low the queue fills, the lexer holds, and in_ready
//  drops once the input register is full; nothing is lost.
//  Reset: arst_n clears the lexer to idle and empties the queue. An unrecognized
//  byte yields an error token, then every further word is consumed silently
//  until the next reset.
module source_tokenizer_unit
	import stu_pkg::*;
#(
	parameter int NUM_CHARS = NUM_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] char_in,
	input  logic              end_mark,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] token_kind,
	output logic [MANT_W-1:0] mantissa,
	output logic [FRAC_W-1:0] fraction_digits,
	output logic [CHAR_W-1:0] char_value,
	output logic              num_overflow,
	output logic              last_result
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;
	logic              advance;
	logic              push_ready;
	logic              res_valid;
	pair_t             res;
	token_t            out_tok;

	// Lex the held word only when the queue has room for its tokens.
	assign advance  = valid_s1 & push_ready;
	assign in_ready = ~valid_s1 | advance;

	// Input register: load on accept, drop valid once the lexer consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			end_s1  <= end_mark;
		end
	end

	stu_lexer #(
		.NUM_CHARS(NUM_CHARS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.chr      (char_s1),
		.end_in   (end_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	stu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance & res_valid),
		.push_data (res),
		.push_ready(push_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_tok   (out_tok)
	);

	assign token_kind      = out_tok.kind;
	assign mantissa        = out_tok.mant;
	assign fraction_digits = out_tok.frac;
	assign char_value      = out_tok.chv;
	assign num_overflow    = out_tok.ovf;
	assign last_result     = out_tok.last;

endmodule

/* rtl/core/stu_lexer.sv */
// Tokenizer state machine: consumes one word per advance, yields up to two tokens.
// Depends on stu_pkg for token codes and the pair_t result struct.
`timescale 1ns / 1ps

module stu_lexer
	import stu_pkg::*;
#(
	parameter int NUM_CHARS = NUM_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [CHAR_W-1:0] chr,
	input  logic              end_in,
	output logic              res_valid,
	output pair_t             res
);

	localparam int CW = $clog2(NUM_CHARS + 1);
	localparam logic [2:0] KP_MISS = 3'd7;
	localparam logic [2:0] KP_DONE = 3'd3;

	typedef enum logic [2:0] {M_IDLE, M_NUM, M_IDENT, M_STR, M_HALT} mode_t;

	mode_t             mode_q, mode_d;
	logic [2:0]        kp_q, kp_d;
	logic [MANT_W-1:0] nv_q, nv_d;
	logic [CW-1:0]     cc_q, cc_d;
	logic [FRAC_W-1:0] fc_q, fc_d;
	logic [1:0]        dc_q, dc_d;
	logic              ovf_q, ovf_d;

	logic is_digit, is_alpha, is_dot, is_quote, is_ws, is_under;
	logic [KIND_W-1:0] op_kind;
	logic              op_hit;
	logic [7:0]        kw_char;
	logic [MANT_W+3:0] mul_sum;
	logic              sat;
	token_t            num_tok, id_tok, f_tok, s_tok;
	logic              f_vld, s_vld, run_ic;

	always_comb begin
		is_digit = chr inside {[8'h30:8'h39]};
		is_alpha = chr inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		is_dot   = (chr == 8'h2E);
		is_quote = (chr == 8'h22);
		is_under = (chr == 8'h5F);
		is_ws    = chr inside {8'h20, [8'h09:8'h0D]};
	end

	always_comb begin
		op_hit  = 1'b1;
		op_kind = K_ERROR;
		case (chr)
			8'h2B: op_kind = K_PLUS;
			8'h2D: op_kind = K_MINUS;
			8'h2A: op_kind = K_STAR;
			8'h2F: op_kind = K_SLASH;
			8'h25: op_kind = K_PCT;
			8'h28: op_kind = K_LPAREN;
			8'h29: op_kind = K_RPAREN;
			8'h5B: op_kind = K_LBRACK;
			8'h5D: op_kind = K_RBRACK;
			8'h7B: op_kind = K_LBRACE;
			8'h7D: op_kind = K_RBRACE;
			8'h3B: op_kind = K_SEMI;
			default: op_hit = 1'b0;
		endcase
	end

	always_comb begin
		case (kp_q)
			3'd0: kw_char = 8'h6C;
			3'd1: kw_char = 8'h65;
			3'd2: kw_char = 8'h74;
			default: kw_char = 8'h00;
		endcase
	end

	// Mantissa step: nv*10 + digit in 41 bits, saturate when it spills past 37.
	assign mul_sum = {1'b0, nv_q, 3'b000} + {3'b000, nv_q, 1'b0} + {37'd0, chr[3:0]};
	assign sat     = |mul_sum[MANT_W+3:MANT_W];

	always_comb begin
		num_tok      = '0;
		num_tok.kind = (dc_q != 2'd0) ? K_FLOAT : K_INT;
		num_tok.mant = nv_q;
		num_tok.frac = (dc_q != 2'd0) ? fc_q : '0;
		num_tok.ovf  = ovf_q;
		id_tok       = '0;
		id_tok.kind  = (kp_q == KP_DONE) ? K_LET : K_IDENT;
	end

	always_comb begin
		mode_d = mode_q;
		kp_d   = kp_q;
		nv_d   = nv_q;
		cc_d   = cc_q;
		fc_d   = fc_q;
		dc_d   = dc_q;
		ovf_d  = ovf_q;
		f_vld  = 1'b0;
		f_tok  = '0;
		s_vld  = 1'b0;
		s_tok  = '0;
		run_ic = 1'b0;

		if (mode_q != M_HALT) begin
			if (end_in) begin
				case (mode_q)
					M_NUM: begin
						f_vld = 1'b1;
						f_tok = num_tok;
					end
					M_IDENT: begin
						f_vld = 1'b1;
						f_tok = id_tok;
					end
					M_STR: begin
						f_vld      = 1'b1;
						f_tok.kind = K_STREND;
					end
					default: ;
				endcase
				s_vld      = 1'b1;
				s_tok.kind = K_EOF;
				mode_d     = M_IDLE;
			end else begin
				case (mode_q)
					M_STR: begin
						f_vld = 1'b1;
						if (is_quote) begin
							f_tok.kind = K_STREND;
							mode_d     = M_IDLE;
						end else begin
							f_tok.kind = K_STRCHAR;
							f_tok.chv  = chr;
						end
					end
					M_NUM: begin
						if (is_digit || is_dot) begin
							if (cc_q >= CW'(NUM_CHARS)) begin
								ovf_d = 1'b1;
							end else begin
								cc_d = cc_q + CW'(1);
								if (is_dot) begin
									if (dc_q < 2'd2)
										dc_d = dc_q + 2'd1;
								end else if (dc_q < 2'd2) begin
									if (sat) begin
										nv_d  = MANT_MAX;
										ovf_d = 1'b1;
									end else begin
										nv_d = mul_sum[MANT_W-1:0];
									end
									if (dc_q == 2'd1 && fc_q != FRAC_MAX)
										fc_d = fc_q + FRAC_W'(1);
								end
							end
						end else begin
							f_vld  = 1'b1;
							f_tok  = num_tok;
							run_ic = 1'b1;
						end
					end
					M_IDENT: begin
						if (is_alpha || is_digit || is_under) begin
							if (kp_q < KP_DONE && chr == kw_char)
								kp_d = kp_q + 3'd1;
							else
								kp_d = KP_MISS;
						end else begin
							f_vld  = 1'b1;
							f_tok  = id_tok;
							run_ic = 1'b1;
						end
					end
					default: run_ic = 1'b1;
				endcase
			end
		end

		// Fresh character from idle, also the terminator of a number or identifier.
		if (run_ic) begin
			mode_d = M_IDLE;
			if (is_ws) begin
				mode_d = M_IDLE;
			end else if (is_digit) begin
				mode_d = M_NUM;
				nv_d   = {33'd0, chr[3:0]};
				cc_d   = CW'(1);
				fc_d   = '0;
				dc_d   = '0;
				ovf_d  = 1'b0;
			end else if (is_alpha || is_under) begin
				mode_d = M_IDENT;
				kp_d   = (chr == 8'h6C) ? 3'd1 : KP_MISS;
			end else if (is_quote) begin
				mode_d = M_STR;
			end else if (op_hit) begin
				s_vld      = 1'b1;
				s_tok.kind = op_kind;
			end else begin
				s_vld      = 1'b1;
				s_tok.kind = K_ERROR;
				s_tok.chv  = chr;
				mode_d     = M_HALT;
			end
		end
	end

	// Pack the flushed token and the fresh one, then flag the last of them.
	always_comb begin
		res       = '0;
		res_valid = f_vld | s_vld;
		if (f_vld) begin
			res.tok[0] = f_tok;
			res.tok[1] = s_tok;
			res.two    = s_vld;
		end else begin
			res.tok[0] = s_tok;
		end
		if (res.two)
			res.tok[1].last = 1'b1;
		else
			res.tok[0].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			kp_q   <= '0;
			nv_q   <= '0;
			cc_q   <= '0;
			fc_q   <= '0;
			dc_q   <= '0;
			ovf_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			kp_q   <= kp_d;
			nv_q   <= nv_d;
			cc_q   <= cc_d;
			fc_q   <= fc_d;
			dc_q   <= dc_d;
			ovf_q  <= ovf_d;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_HALT |=> mode_q == M_HALT)
		else $error("tokenizer left halt without reset");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= CW'(NUM_CHARS))
		else $error("number character count past limit");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_HALT |-> !res_valid)
		else $error("halted tokenizer produced a token");

endmodule

/* rtl/core/stu_out_fifo.sv */
// Two-entry result queue; each entry holds the one or two tokens of one word.
// Depends on stu_pkg for pair_t and token_t.
`timescale 1ns / 1ps

module stu_out_fifo
	import stu_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  pair_t  push_data,
	output logic   push_ready,
	output logic   out_valid,
	input  logic   out_ready,
	output token_t out_tok
);

	localparam int DEPTH = 2;
	localparam int IW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	pair_t           ent_q [DEPTH];
	logic [IW-1:0]   rp_q, wp_q;
	logic [NW-1:0]   cnt_q;
	logic            sub_q;
	pair_t           head;
	logic            pop_tok, pop_ent;

	assign head       = ent_q[rp_q];
	assign out_valid  = (cnt_q != '0);
	assign out_tok    = head.tok[sub_q];
	assign push_ready = (cnt_q < NW'(DEPTH));
	assign pop_tok    = out_valid & out_ready;
	assign pop_ent    = pop_tok & (sub_q | ~head.two);

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
			sub_q <= 1'b0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop_ent)
				rp_q <= rp_q + 1'b1;
			if (pop_tok)
				sub_q <= ~pop_ent;
			cnt_q <= cnt_q + NW'(push) - NW'(pop_ent);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready)
		else $error("result queue written while full");

	a_sub_two: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> out_valid && head.two)
		else $error("second slot selected on a single-token entry");

	a_sub_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sub_q) && $stable(rp_q))
		else $error("queue head moved while output stalled");

endmodule
